@@ sv/fst_pkg.sv @@
// Shared widths, register codes and handshake structs for the FIFO sample timestamper.
`timescale 1ns / 1ps
`default_nettype none

package fst_pkg;

    localparam int TIME_W      = 64;
    localparam int IRQ_W       = 63;
    localparam int CNT_W       = 16;
    localparam int SLOT_W      = 6;
    localparam int NOMINAL_W   = 32;
    localparam int SKIP_W      = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_LIMIT = 64;
    localparam int DIVISOR_W   = 7;
    localparam int DIV_STEP_W  = 6;

    localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 32'd1000000;
    localparam logic [SKIP_W-1:0]    SKIP_RESET    = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SKIP   = 2'd1;

    typedef struct packed {
        logic                  start;
        logic [TIME_W-1:0]     dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/fifo_sample_timestamper_core.sv @@
// Top level: interrupt sequencer, period estimate, per-sample timestamp emission.
// A flush result is registered from S_FLUSH once the output is free.
// With a previous time the first sample waits for the serial divide (one quotient bit a
// cycle), then multiply and subtract; without one it waits only for multiply and subtract.
// A new interrupt is taken only in idle, once the previous batch is done; output stalls delay it.
// Reset (async, active low) restores nominal period 1000000 and skip count 0.
`timescale 1ns / 1ps
`default_nettype none

module fifo_sample_timestamper_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [fst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fst_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [fst_pkg::IRQ_W-1:0]       irq_time,
    input  wire logic [fst_pkg::CNT_W-1:0]       sample_count,
    input  wire logic                            threshold_hit,
    input  wire logic                            data_ready,
    input  wire logic                            fifo_full,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [fst_pkg::TIME_W-1:0]    sample_time,
    output logic [fst_pkg::SLOT_W-1:0]           sample_slot,
    output logic                                 flushed,
    output logic                                 last_of_batch
);
    import fst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_DIV,
        S_MUL,
        S_SUB,
        S_EMIT
    } seq_state_t;

    seq_state_t            state_reg;
    logic [NOMINAL_W-1:0]  nominal_reg;
    logic [IRQ_W-1:0]      last_irq_reg;
    logic [TIME_W-1:0]     period_reg;
    logic [TIME_W-1:0]     next_time_reg;
    logic [SKIP_W-1:0]     skip_left_reg;
    logic [IRQ_W-1:0]      t_reg;
    logic [DIVISOR_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [TIME_W-1:0]     prod_reg;
    logic                  out_valid_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_flushed_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    logic                  out_free;
    logic                  is_flush;
    logic                  last_slot;
    logic [SLOT_W-1:0]     cnt_m1;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        in_fire   = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        is_flush  = (!threshold_hit && !data_ready) || fifo_full
                    || (sample_count > CNT_W'(COUNT_LIMIT));
        cnt_m1    = SLOT_W'(cnt_reg - 1'b1);
        last_slot = ({1'b0, slot_reg} == (cnt_reg - 1'b1));

        div_req.start    = in_fire && !is_flush && (sample_count != '0)
                           && (last_irq_reg != '0);
        div_req.dividend = {1'b0, irq_time} - {1'b0, last_irq_reg};
        div_req.divisor  = sample_count[DIVISOR_W-1:0];
    end

    fst_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            nominal_reg     <= NOMINAL_RESET;
            last_irq_reg    <= '0;
            period_reg      <= TIME_W'(NOMINAL_RESET);
            next_time_reg   <= '0;
            skip_left_reg   <= SKIP_RESET;
            t_reg           <= '0;
            cnt_reg         <= '0;
            slot_reg        <= '0;
            prod_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_time_reg    <= '0;
            out_slot_reg    <= '0;
            out_flushed_reg <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (is_flush)
                        begin
                            last_irq_reg <= '0;
                            period_reg   <= TIME_W'(nominal_reg);
                            state_reg    <= S_FLUSH;
                        end
                        else if (sample_count != '0)
                        begin
                            t_reg        <= irq_time;
                            cnt_reg      <= sample_count[DIVISOR_W-1:0];
                            last_irq_reg <= irq_time;
                            state_reg    <= (last_irq_reg != '0) ? S_DIV : S_MUL;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_time_reg    <= '0;
                        out_slot_reg    <= '0;
                        out_flushed_reg <= 1'b1;
                        out_last_reg    <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        period_reg <= div_rsp.quotient;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= period_reg * {{(TIME_W-SLOT_W){1'b0}}, cnt_m1};
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    next_time_reg <= {1'b0, t_reg} - prod_reg;
                    slot_reg      <= '0;
                    state_reg     <= S_EMIT;
                end
                S_EMIT:
                begin
                    // skipped samples form a prefix of the batch
                    if (skip_left_reg != '0 || out_free)
                    begin
                        if (skip_left_reg != '0)
                        begin
                            skip_left_reg <= skip_left_reg - 1'b1;
                        end
                        else
                        begin
                            out_valid_reg   <= 1'b1;
                            out_time_reg    <= next_time_reg;
                            out_slot_reg    <= slot_reg;
                            out_flushed_reg <= 1'b0;
                            out_last_reg    <= last_slot;
                            next_time_reg   <= next_time_reg + period_reg;
                        end
                        if (last_slot)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NOMINAL_PERIOD:
                    begin
                        nominal_reg <= cfg_data[NOMINAL_W-1:0];
                        period_reg  <= TIME_W'(cfg_data[NOMINAL_W-1:0]);
                    end
                    CFG_INITIAL_SKIP:
                    begin
                        skip_left_reg <= cfg_data[SKIP_W-1:0];
                    end
                    default:
                    begin
                        // drop writes to unknown registers
                    end
                endcase
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_time   = out_time_reg;
    assign sample_slot   = out_slot_reg;
    assign flushed       = out_flushed_reg;
    assign last_of_batch = out_last_reg;

endmodule

`default_nettype wire

@@ sv/fst_div.sv @@
// Bit-serial signed divider: 64-bit signed dividend by a small positive divisor.
`timescale 1ns / 1ps
`default_nettype none

module fst_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fst_pkg::div_req_t req,
    output fst_pkg::div_rsp_t      rsp
);
    import fst_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_ABS,
        D_RUN,
        D_SIGN
    } div_state_t;

    div_state_t            state_reg;
    logic [TIME_W-1:0]     num_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic                  neg_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  q_bit;

    always_comb
    begin
        trial     = {rem_reg, num_reg[TIME_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        q_bit     = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            num_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        num_reg   <= req.dividend;
                        den_reg   <= req.divisor;
                        neg_reg   <= req.dividend[TIME_W-1];
                        state_reg <= D_ABS;
                    end
                end
                D_ABS:
                begin
                    if (neg_reg)
                    begin
                        num_reg <= -num_reg;
                    end
                    rem_reg   <= '0;
                    step_reg  <= '1;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    // shift one dividend bit into the remainder, one quotient bit out
                    rem_reg <= q_bit ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                    num_reg <= {num_reg[TIME_W-2:0], q_bit};
                    if (step_reg == '0)
                    begin
                        state_reg <= D_SIGN;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                D_SIGN:
                begin
                    // truncate toward zero: negate the magnitude quotient
                    if (neg_reg)
                    begin
                        num_reg <= -num_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

`default_nettype wire

@@ test/tb_fifo_sample_timestamper_core.sv @@
// Self-checking testbench for the FIFO sample timestamper core: directed cases, backpressure, random traffic.
`timescale 1ns / 1ps

module tb_fifo_sample_timestamper_core;
    import fst_pkg::*;

    // Indexes that map to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;
    localparam int                   QUIET_CYCLES = 1000;
    localparam logic [IRQ_W-1:0]     IRQ_TIME_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [SLOT_W-1:0] slot;
        logic              flush;
        logic              last;
    } stamp_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [IRQ_W-1:0]      irq_time      = '0;
    logic [CNT_W-1:0]      sample_count  = '0;
    logic                  threshold_hit = 1'b0;
    logic                  data_ready    = 1'b0;
    logic                  fifo_full     = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic signed [TIME_W-1:0] sample_time;
    logic [SLOT_W-1:0]     sample_slot;
    logic                  flushed;
    logic                  last_of_batch;

    // Timestamp predictor state and its copy of the registers
    logic [NOMINAL_W-1:0]  nominal_reg = NOMINAL_RESET;
    logic [TIME_W-1:0]     prev_irq    = '0;
    logic [TIME_W-1:0]     period_est  = {32'd0, NOMINAL_RESET};
    logic [TIME_W-1:0]     next_stamp  = '0;
    logic [SKIP_W-1:0]     skips_left  = SKIP_RESET;

    stamp_t           expected_stamps[$];
    int               mismatches       = 0;
    int               irqs_sent        = 0;
    int               flushes_expected = 0;
    int               stamps_checked   = 0;
    int               settings_used    = 0;
    int               hold_cycles      = 0;
    bit               tx_idle          = 1'b0;
    bit               rx_idle          = 1'b0;
    logic [IRQ_W-1:0] irq_clock        = '0;

    fifo_sample_timestamper_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .irq_time      (irq_time),
        .sample_count  (sample_count),
        .threshold_hit (threshold_hit),
        .data_ready    (data_ready),
        .fifo_full     (fifo_full),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_time   (sample_time),
        .sample_slot   (sample_slot),
        .flushed       (flushed),
        .last_of_batch (last_of_batch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 3);
        else if (r < 9)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [IRQ_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[IRQ_W-1:0];
    endfunction

    task automatic predict_stamps(input logic [IRQ_W-1:0] t, input logic [CNT_W-1:0] cnt,
                                  input logic ths, input logic drdy, input logic full);
        logic [TIME_W-1:0] t64;
        logic [TIME_W-1:0] cnt64;
        longint            elapsed;
        stamp_t            r;
        stamp_t            held;
        bit                have_held;
        int                i;
        t64       = {1'b0, t};
        cnt64     = {48'd0, cnt};
        have_held = 1'b0;
        r         = '0;
        held      = '0;
        if ((!ths && !drdy) || full || cnt > COUNT_LIMIT) begin
            // drop the history and fall back to the nominal period
            prev_irq   = '0;
            period_est = {32'd0, nominal_reg};
            r.flush    = 1'b1;
            r.last     = 1'b1;
            expected_stamps.push_back(r);
            flushes_expected++;
        end
        else if (cnt != '0) begin
            if (prev_irq != '0) begin
                elapsed    = longint'(t64) - longint'(prev_irq);
                period_est = elapsed / longint'(cnt64);
            end
            next_stamp = t64 - (cnt64 - 64'd1) * period_est;
            prev_irq   = t64;
            for (i = 0; i < int'(cnt); i++) begin
                if (skips_left != '0)
                    skips_left--;
                else begin
                    if (have_held)
                        expected_stamps.push_back(held);
                    held.stamp = next_stamp;
                    held.slot  = SLOT_W'(i);
                    held.flush = 1'b0;
                    held.last  = 1'b0;
                    have_held  = 1'b1;
                    next_stamp = next_stamp + period_est;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_stamps.push_back(held);
            end
        end
    endtask

    task automatic check_stamp();
        stamp_t want;
        if (expected_stamps.size() == 0) begin
            $error("result with nothing expected: sample_time %h slot %0d flushed %b",
                   sample_time, sample_slot, flushed);
            mismatches++;
        end
        else begin
            want = expected_stamps.pop_front();
            stamps_checked++;
            if (sample_time !== want.stamp) begin
                $error("sample_time: expected %h, actual %h", want.stamp, sample_time);
                mismatches++;
            end
            if (sample_slot !== want.slot) begin
                $error("sample_slot: expected %0d, actual %0d", want.slot, sample_slot);
                mismatches++;
            end
            if (flushed !== want.flush) begin
                $error("flushed: expected %b, actual %b", want.flush, flushed);
                mismatches++;
            end
            if (last_of_batch !== want.last) begin
                $error("last_of_batch: expected %b, actual %b", want.last, last_of_batch);
                mismatches++;
            end
        end
    endtask

    task automatic send_irq(input logic [IRQ_W-1:0] t, input logic [CNT_W-1:0] cnt,
                            input logic ths, input logic drdy, input logic full);
        int gap;
        in_valid      <= 1'b1;
        irq_time      <= t;
        sample_count  <= cnt;
        threshold_hit <= ths;
        data_ready    <= drdy;
        fifo_full     <= full;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_stamps(t, cnt, ths, drdy, full);
        irqs_sent++;
        if (tx_idle) begin
            gap = gap_cycles();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_stamps.size() != 0)
            @(posedge clk);
    endtask

    // An item that emits nothing may still be in the divider; let it finish.
    task automatic settle();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_NOMINAL_PERIOD) begin
            nominal_reg = data[NOMINAL_W-1:0];
            period_est  = {32'd0, data[NOMINAL_W-1:0]};
            settings_used++;
        end
        else if (idx == CFG_INITIAL_SKIP) begin
            skips_left = data[SKIP_W-1:0];
            settings_used++;
        end
    endtask

    task automatic send_random_irq(input logic [IRQ_W-1:0] seq_period, output bit counted);
        int               kind;
        int               st;
        logic [IRQ_W-1:0] t;
        logic [CNT_W-1:0] cnt;
        logic             ths;
        logic             drdy;
        logic             full;
        kind    = $urandom_range(0, 99);
        counted = 1'b1;
        if ($urandom_range(0, 4) == 0)
            cnt = CNT_W'($urandom_range(17, COUNT_LIMIT));
        else
            cnt = CNT_W'($urandom_range(1, 16));
        st   = $urandom_range(1, 3);
        ths  = st[0];
        drdy = st[1];
        full = 1'b0;
        t    = irq_clock;
        if (kind < 66) begin
            // well-formed watermark interrupt: about count periods after the last one
            irq_clock = irq_clock + {47'd0, cnt} * seq_period + IRQ_W'($urandom_range(0, 255));
            t         = irq_clock;
        end
        else if (kind < 76) begin
            t = rand_time();
            case ($urandom_range(0, 2))
                0: begin
                    ths  = 1'b0;
                    drdy = 1'b0;
                    full = 1'($urandom_range(0, 1));
                    cnt  = CNT_W'($urandom_range(0, 65535));
                end
                1: begin
                    full = 1'b1;
                    cnt  = CNT_W'($urandom_range(0, 65535));
                end
                default: cnt = CNT_W'($urandom_range(COUNT_LIMIT + 1, 65535));
            endcase
        end
        else if (kind < 80) begin
            cnt     = '0;
            counted = 1'b0;
        end
        else if (kind < 95) begin
            t         = rand_time();
            irq_clock = t;
        end
        else begin
            t         = '0;
            irq_clock = '0;
        end
        send_irq(t, cnt, ths, drdy, full);
    endtask

    task automatic random_phase(input logic [CFG_DATA_W-1:0] nominal,
                                input logic [CFG_DATA_W-1:0] skip,
                                input logic [IRQ_W-1:0] seq_period,
                                input bit tx, input bit rx, input int items);
        int sent;
        bit counted;
        settle();
        write_reg(CFG_NOMINAL_PERIOD, nominal);
        write_reg(CFG_INITIAL_SKIP, skip);
        tx_idle = tx;
        rx_idle = rx;
        sent    = 0;
        while (sent < items) begin
            send_random_irq(seq_period, counted);
            if (counted)
                sent++;
        end
    endtask

    task automatic test_flush_and_count_cases();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        // no history yet: nominal period, early samples wrap below zero
        send_irq(63'd5000, 16'd4, 1'b1, 1'b0, 1'b0);
        send_irq(63'd9000, 16'd4, 1'b0, 1'b1, 1'b0);
        send_irq(63'd105037, 16'd64, 1'b1, 1'b1, 1'b0);
        send_irq(rand_time(), 16'd5, 1'b0, 1'b0, 1'b0);
        send_irq(63'd200000, 16'd0, 1'b1, 1'b0, 1'b0);
        send_irq(63'd0, 16'd1, 1'b1, 1'b0, 1'b0);
        // previous time was zero, so this one still has no history
        send_irq(IRQ_TIME_MAX, 16'd3, 1'b1, 1'b0, 1'b0);
        send_irq(63'd1000, 16'd7, 1'b0, 1'b1, 1'b0);
        send_irq(63'd2000, 16'd64, 1'b1, 1'b1, 1'b1);
        send_irq(63'd3000, 16'd65, 1'b1, 1'b0, 1'b0);
        send_irq(63'd4000, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        send_irq(63'd5000, 16'd0, 1'b0, 1'b0, 1'b0);
        send_irq(63'd6000, 16'd0, 1'b1, 1'b1, 1'b1);
        send_irq(63'd123456, 16'd1, 1'b1, 1'b0, 1'b0);
        send_irq(63'd124233, 16'd1, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_register_writes();
        int k;
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        write_reg(CFG_NOMINAL_PERIOD, 32'd1);
        write_reg(CFG_INITIAL_SKIP, 32'hABCD_0003);
        send_irq(63'd50, 16'd2, 1'b1, 1'b0, 1'b0);
        send_irq(63'd80, 16'd3, 1'b0, 1'b1, 1'b0);
        send_irq(63'd90, 16'd4, 1'b0, 1'b0, 1'b0);
        send_irq(63'd99, 16'd4, 1'b1, 1'b0, 1'b0);
        settle();
        write_reg(CFG_NOMINAL_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_INITIAL_SKIP, 32'd255);
        for (k = 1; k <= 4; k++)
            send_irq(IRQ_W'(k * 70000), 16'd64, 1'b1, 1'b1, 1'b0);
        send_irq(63'd400000, 16'd64, 1'b1, 1'b1, 1'b1);
        send_irq(63'd5, 16'd64, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_backpressure();
        int k;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = 900;
        for (k = 0; k < 10; k++) begin
            irq_clock = irq_clock + IRQ_W'(40 * 2500 + k);
            send_irq(irq_clock, 16'd40, 1'b1, 1'b1, 1'b0);
        end
        // hold off the sender until the block has handed over everything
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (k = 0; k < 5; k++) begin
            irq_clock = irq_clock + IRQ_W'(64 * 3000);
            send_irq(irq_clock, CNT_W'($urandom_range(1, COUNT_LIMIT)), 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        random_phase(CFG_DATA_W'($urandom_range(1, 2000000)), '0,
                     IRQ_W'($urandom_range(500, 50000)), 1'b1, 1'b1, 75);
        random_phase(32'd1, CFG_DATA_W'($urandom_range(1, 40)),
                     IRQ_W'($urandom_range(1, 100)), 1'b0, 1'b0, 65);
        random_phase(32'hFFFF_FFFF, '0, IRQ_W'($urandom), 1'b1, 1'b0, 75);
        random_phase(CFG_DATA_W'($urandom_range(1, 32'hFFFF_FFFF)),
                     CFG_DATA_W'($urandom_range(0, 255)),
                     IRQ_W'($urandom_range(1, 1000000)), 1'b0, 1'b1, 75);
    endtask

    // Result side: check each transaction, then pick the stall for the next cycle.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
                check_stamp();
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else begin
                if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0)
                    stall_left = gap_cycles();
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_flush_and_count_cases();
        test_register_writes();
        test_backpressure();
        test_random_traffic();
        settle();
        $display("Run covered %0d interrupts (%0d flushes) and %0d checked results",
                 irqs_sent, flushes_expected, stamps_checked);
        $display("across %0d register settings, with stalls and backpressure on both sides.",
                 settings_used);
        if (mismatches == 0)
            $display("PASS fifo_sample_timestamper_core");
        else
            $display("FAIL fifo_sample_timestamper_core");
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $error("timeout with %0d results still expected", expected_stamps.size());
        $display("FAIL fifo_sample_timestamper_core");
        $finish;
    end

endmodule
